FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

FILE: src/cdn_pkg.sv
// Shared types, register indexes and codon table for the codon translator.
// No dependencies.
`timescale 1ns / 1ps

package cdn_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_PRIME_LENGTH = 2'd1;

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [1:0]       LAST_PHASE = 2'd2;
  localparam logic [6:0]       STOP_LETTER = 7'h58;  // 'X' marks a stop codon
  // floor(n / 3) == (n * RECIP3) >> 17 for any 16-bit n
  localparam logic [16:0]      RECIP3 = 17'd43691;

  // Standard genetic code, indexed by {b0, b1, b2} with A=0 C=1 G=2 T=3
  localparam logic [511:0] AMINO_STR =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVVXYXYSSSSXCWCLFLF";

  typedef struct packed {
    logic [2:0] base;
    logic       last_base;
  } cdn_in_t;

  typedef struct packed {
    logic [6:0]  amino;
    logic        amino_valid;
    logic        ended;
    logic        ended_by_stop;
    logic [14:0] whole_codons_5p;
    logic [1:0]  leftover_bases_5p;
  } cdn_out_t;

  // Classified codon result passed from the front to the back
  typedef struct packed {
    logic [6:0] amino;
    logic       amino_valid;
    logic       ended;
    logic       ended_by_stop;
  } cdn_entry_t;

  function automatic logic [6:0] amino_letter(input logic [5:0] idx);
    return AMINO_STR[{~idx, 3'b000} +: 7];
  endfunction

endpackage

FILE: src/codon_to_peptide_translator.sv
// Codon translator: one base per cycle in unless stalled, one result per codon or read end.
// Path: each result is written into the queue, then registered in the output register.
// Throughput: one base per cycle; a two-entry queue decouples the codon front
// end from the output register, so an output stall holds off input only when full.
// Reset: synchronous; start_position returns to 1, five_prime_length to 0,
// frame state is cleared. No clearing pass. Depends on cdn_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module codon_to_peptide_translator import cdn_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cdn_in_t              in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cdn_out_t             out_payload,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  logic [POS_W-1:0] start_pos_r, five_len_r, start_eff;
  logic             accept, q_push, q_pop, q_full, q_empty;
  cdn_entry_t       q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= POS_W'(1);
      five_len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_POSITION:    start_pos_r <= cfg_data;
        REG_FIVE_PRIME_LENGTH: five_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A start position of zero behaves as one
  assign start_eff = (start_pos_r == '0) ? POS_W'(1) : start_pos_r;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  cdn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_payload),
    .start_eff (start_eff),
    .push      (q_push),
    .entry     (q_wdata)
  );

  cdn_queue #(.DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  cdn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_eff   (start_eff),
    .five_len    (five_len_r),
    .entry       (q_rdata),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

  `ASSERT_IMPLY(a_no_overflow, q_push, !q_full, "queue push while full")
  `ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty, "queue pop while empty")
  `ASSERT_IMPLY(a_stop_ends, out_valid && out_payload.ended_by_stop,
    out_payload.ended && !out_payload.amino_valid, "stop result not final")

endmodule

FILE: src/cdn_front.sv
// Front end: tracks reading frame, assembles codons and classifies them.
// Depends on cdn_pkg.
`timescale 1ns / 1ps

module cdn_front import cdn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  cdn_in_t          item,
  input  logic [POS_W-1:0] start_eff,
  output logic             push,
  output cdn_entry_t       entry
);

  logic [POS_W-1:0] base_pos_r, base_pos_nxt;
  logic [3:0]       codon_r, codon_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             unknown_r, unknown_nxt;
  logic             stopped_r, stopped_nxt;

  logic [POS_W-1:0] pos;
  logic             in_frame, complete, unknown_c, is_stop;
  logic [5:0]       codon_idx;
  logic [6:0]       letter;

  always_comb begin
    pos       = (base_pos_r != POS_MAX) ? base_pos_r + 1'b1 : POS_MAX;
    in_frame  = pos >= start_eff;
    unknown_c = unknown_r | item.base[2];
    codon_idx = {codon_r, item.base[1:0]};
    letter    = amino_letter(codon_idx);
    complete  = in_frame && (phase_r == LAST_PHASE);
    is_stop   = complete && !unknown_c && (letter == STOP_LETTER);

    entry.amino         = (complete && !unknown_c && !is_stop) ? letter : '0;
    entry.amino_valid   = complete && !is_stop;
    entry.ended         = is_stop || item.last_base;
    entry.ended_by_stop = is_stop;
    push = accept && !stopped_r && (complete || item.last_base);

    base_pos_nxt = base_pos_r;
    codon_nxt    = codon_r;
    phase_nxt    = phase_r;
    unknown_nxt  = unknown_r;
    stopped_nxt  = stopped_r;
    if (accept) begin
      if (item.last_base) begin
        base_pos_nxt = '0;
        codon_nxt    = '0;
        phase_nxt    = '0;
        unknown_nxt  = 1'b0;
        stopped_nxt  = 1'b0;
      end else if (!stopped_r) begin
        base_pos_nxt = pos;
        if (complete) begin
          codon_nxt   = '0;
          phase_nxt   = '0;
          unknown_nxt = 1'b0;
          stopped_nxt = is_stop;
        end else if (in_frame) begin
          codon_nxt   = codon_idx[3:0];
          phase_nxt   = phase_r + 1'b1;
          unknown_nxt = unknown_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_pos_r <= '0;
      codon_r    <= '0;
      phase_r    <= '0;
      unknown_r  <= 1'b0;
      stopped_r  <= 1'b0;
    end else begin
      base_pos_r <= base_pos_nxt;
      codon_r    <= codon_nxt;
      phase_r    <= phase_nxt;
      unknown_r  <= unknown_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

FILE: src/cdn_queue.sv
// Small FIFO between the classifying front end and the output back end.
// Depends on cdn_pkg.
`timescale 1ns / 1ps

module cdn_queue import cdn_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cdn_entry_t wdata,
  input  logic       pop,
  output cdn_entry_t rdata,
  output logic       full,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cdn_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/cdn_back.sv
// Back end: precomputes the 5' codon counts and drives the output register.
// Depends on cdn_pkg.
`timescale 1ns / 1ps

module cdn_back import cdn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [POS_W-1:0] start_eff,
  input  logic [POS_W-1:0] five_len,
  input  cdn_entry_t       entry,
  input  logic             q_empty,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output cdn_out_t         out_payload
);

  logic [POS_W:0]   span;
  logic [POS_W-1:0] n;
  logic [32:0]      prod;
  logic [14:0]      whole_c, whole_r;
  logic [POS_W-1:0] three_w, rem;
  logic [1:0]       left_r;
  logic             out_valid_r, out_valid_nxt;
  cdn_out_t         out_r;

  // Counts only move on configuration writes; one register stage is enough
  always_comb begin
    span    = {1'b0, five_len} + 1'b1 - {1'b0, start_eff};
    n       = ({1'b0, five_len} + 1'b1 >= {1'b0, start_eff}) ? span[POS_W-1:0] : '0;
    prod    = n * RECIP3;
    whole_c = prod[31:17];
    three_w = {whole_c, 1'b0} + {1'b0, whole_c};
    rem     = n - three_w;
  end

  assign pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    whole_r <= whole_c;
    left_r  <= rem[1:0];
    if (pop) begin
      out_r.amino             <= entry.amino;
      out_r.amino_valid       <= entry.amino_valid;
      out_r.ended             <= entry.ended;
      out_r.ended_by_stop     <= entry.ended_by_stop;
      out_r.whole_codons_5p   <= whole_r;
      out_r.leftover_bases_5p <= left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

FILE: verif/tb_codon_to_peptide_translator.sv
// Self-checking bench for codon_to_peptide_translator: a directed table and random reads
// go through a codon predictor; results are checked field by field. Depends on cdn_pkg.
`timescale 1ns / 1ps

module tb_codon_to_peptide_translator;
  import cdn_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned STALL_LIMIT   = 2000;

  localparam logic [2:0] BASE_A         = 3'd0;
  localparam logic [2:0] BASE_C         = 3'd1;
  localparam logic [2:0] BASE_G         = 3'd2;
  localparam logic [2:0] BASE_T         = 3'd3;
  localparam logic [2:0] BASE_OTHER     = 3'd4;
  localparam logic [2:0] BASE_OTHER_MAX = 3'd7;

  // Standard code, letter i sits at character i of the string
  localparam logic [8*64-1:0] CODE_LETTERS =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVVXYXYSSSSXCWCLFLF";

  localparam cdn_out_t NO_RESULT     = '0;
  localparam cdn_out_t MET_START     = '{7'h4D, 1'b1, 1'b0, 1'b0, 15'd0, 2'd0};
  localparam cdn_out_t UNKNOWN_CODON = '{7'h00, 1'b1, 1'b0, 1'b0, 15'd0, 2'd0};
  localparam cdn_out_t STOP_END      = '{7'h00, 1'b0, 1'b1, 1'b1, 15'd0, 2'd0};
  localparam cdn_out_t BARE_END      = '{7'h00, 1'b0, 1'b1, 1'b0, 15'd0, 2'd0};

  typedef struct packed {
    cdn_in_t  item;
    bit       typed;
    cdn_out_t want;
  } probe_row_t;

  localparam int PROBE_ROWS = 28;

  // Runs under the reset settings: start 1, empty 5' part
  probe_row_t probe_table [PROBE_ROWS] = '{
    '{'{BASE_A, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_G, 1'b0}, 1'b1, MET_START},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_OTHER, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_OTHER_MAX, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_A, 1'b0}, 1'b1, UNKNOWN_CODON},
    '{'{BASE_G, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_C, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_C, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_A, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_A, 1'b0}, 1'b1, STOP_END},
    '{'{BASE_G, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_OTHER, 1'b1}, 1'b0, NO_RESULT},
    '{'{BASE_C, 1'b1}, 1'b1, BARE_END},
    '{'{BASE_A, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_C, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_G, 1'b1}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_G, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_A, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_OTHER_MAX, 1'b1}, 1'b0, NO_RESULT},
    '{'{BASE_T, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_A, 1'b0}, 1'b0, NO_RESULT},
    '{'{BASE_G, 1'b1}, 1'b0, NO_RESULT}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  cdn_in_t              in_payload = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  cdn_out_t             out_payload;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_START_POSITION;
  logic [POS_W-1:0]     cfg_data   = '0;

  // Predictor copy of the registers and the frame state
  int unsigned frame_start   = 1;
  int unsigned utr_len       = 0;
  int unsigned base_pos      = 0;
  logic [5:0]  codon_acc     = '0;
  int unsigned codon_phase   = 0;
  bit          seq_halted    = 1'b0;
  bit          codon_unknown = 1'b0;

  cdn_out_t    pending_residues [$];
  int unsigned send_idle_pct    = 37;
  int unsigned recv_stall_pct   = 78;
  int unsigned live_bases       = 0;
  int unsigned residues_checked = 0;
  int unsigned settings_loaded  = 0;
  int unsigned mismatches       = 0;
  int unsigned strays           = 0;
  int unsigned quiet_cycles     = 0;

  codon_to_peptide_translator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void clear_frame();
    base_pos      = 0;
    codon_acc     = '0;
    codon_phase   = 0;
    seq_halted    = 1'b0;
    codon_unknown = 1'b0;
  endfunction

  // Advance the frame by one base; returns 1 when the base yields a residue
  function automatic bit translate_base(input cdn_in_t it, output cdn_out_t res);
    int unsigned eff;
    int unsigned span;
    int unsigned pos;
    int          idx;
    bit          emit;
    bit          stop;
    logic [6:0]  letter;
    res  = '0;
    emit = 1'b0;
    stop = 1'b0;
    eff  = (frame_start == 0) ? 1 : frame_start;
    if (utr_len + 1 >= eff) begin
      span = utr_len + 1 - eff;
      res.whole_codons_5p   = 15'(span / 3);
      res.leftover_bases_5p = 2'(span % 3);
    end
    if (seq_halted) begin
      if (it.last_base) clear_frame();
      return 1'b0;
    end
    pos = (base_pos < 65535) ? base_pos + 1 : 65535;
    base_pos = pos;
    if (pos >= eff) begin
      if (it.base > BASE_T) codon_unknown = 1'b1;
      codon_acc = {codon_acc[3:0], it.base[1:0]};
      if (codon_phase == 2) begin
        emit   = 1'b1;
        idx    = 63 - int'(codon_acc);
        letter = CODE_LETTERS[idx * 8 +: 7];
        if (codon_unknown) begin
          res.amino_valid = 1'b1;
        end else if (letter == STOP_LETTER) begin
          stop = 1'b1;
        end else begin
          res.amino       = letter;
          res.amino_valid = 1'b1;
        end
        codon_phase   = 0;
        codon_acc     = '0;
        codon_unknown = 1'b0;
      end else begin
        codon_phase++;
      end
    end
    if (stop) seq_halted = 1'b1;
    res.ended         = stop | it.last_base;
    res.ended_by_stop = stop;
    if (it.last_base) begin
      emit = 1'b1;
      clear_frame();
    end
    return emit;
  endfunction

  task automatic feed_base(input cdn_in_t it, input bit typed, input cdn_out_t want);
    cdn_out_t guess;
    bit       emits;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (in_stall);
    if (!seq_halted) live_bases++;
    emits = translate_base(it, guess);
    if (emits) pending_residues.insert(pending_residues.size(), typed ? want : guess);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_residues.size() != 0);
  endtask

  task automatic load_frame(input logic [POS_W-1:0] start_val,
                            input logic [POS_W-1:0] len_val);
    hold_until_drained();
    // a base after a stop may still be in flight with no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_POSITION;
    cfg_data  <= start_val;
    do @(posedge clk); while (!cfg_ready);
    frame_start = start_val;
    cfg_index <= REG_FIVE_PRIME_LENGTH;
    cfg_data  <= len_val;
    do @(posedge clk); while (!cfg_ready);
    utr_len = len_val;
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Mostly clean reads with sparse unknown bases, some noise and very short reads
  task automatic stream_reads(input int unsigned budget, input bit mid_drain);
    int unsigned first;
    int unsigned len;
    int unsigned kind;
    int unsigned k;
    cdn_in_t     it;
    first = live_bases;
    while (live_bases - first < budget) begin
      kind = $urandom_range(9);
      if (kind == 0) len = $urandom_range(12, 1);
      else if (kind == 1) len = $urandom_range(2, 1);
      else len = $urandom_range(45, 3);
      for (k = 0; k < len; k++) begin
        if (kind == 0 || $urandom_range(15) == 0) it.base = 3'($urandom_range(7));
        else it.base = 3'($urandom_range(3));
        it.last_base = (k == len - 1);
        feed_base(it, 1'b0, NO_RESULT);
      end
      if (mid_drain && live_bases - first >= budget / 2) begin
        hold_until_drained();
        mid_drain = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    cdn_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_residues.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("unexpected result: amino=%h valid=%b ended=%b stop=%b whole=%0d left=%0d",
                   out_payload.amino, out_payload.amino_valid, out_payload.ended,
                   out_payload.ended_by_stop, out_payload.whole_codons_5p,
                   out_payload.leftover_bases_5p);
      end else begin
        want = pending_residues.pop_front();
        residues_checked++;
        if (out_payload.amino !== want.amino ||
            out_payload.amino_valid !== want.amino_valid ||
            out_payload.ended !== want.ended ||
            out_payload.ended_by_stop !== want.ended_by_stop ||
            out_payload.whole_codons_5p !== want.whole_codons_5p ||
            out_payload.leftover_bases_5p !== want.leftover_bases_5p) begin
          mismatches++;
          if (mismatches + strays <= 10)
            $display("residue %0d: exp amino=%h valid=%b ended=%b stop=%b whole=%0d left=%0d",
                     residues_checked, want.amino, want.amino_valid, want.ended,
                     want.ended_by_stop, want.whole_codons_5p, want.leftover_bases_5p,
                     "\n             got amino=%h valid=%b ended=%b stop=%b whole=%0d left=%0d",
                     out_payload.amino, out_payload.amino_valid, out_payload.ended,
                     out_payload.ended_by_stop, out_payload.whole_codons_5p,
                     out_payload.leftover_bases_5p);
        end
      end
    end
  end

  // Count cycles without any transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < PROBE_ROWS; k++)
      feed_base(probe_table[k].item, probe_table[k].typed, probe_table[k].want);

    load_frame(16'd1, 16'hFFFF);
    stream_reads(100, 1'b1);
    load_frame(16'd0, 16'd10);
    stream_reads(90, 1'b0);

    send_idle_pct  = 78;
    recv_stall_pct = 37;
    load_frame(16'd5, 16'hFFFF);
    stream_reads(90, 1'b0);
    load_frame(16'($urandom_range(8, 1)), 16'($urandom_range(60)));
    stream_reads(90, 1'b0);
    load_frame(16'd40, 16'd3);
    stream_reads(50, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Frame opens past every short read, so only bare end results come back
    load_frame(16'hFFFF, 16'd0);
    stream_reads(40, 1'b0);
    load_frame(16'($urandom_range(4, 1)), 16'($urandom_range(65535)));
    stream_reads(60, 1'b0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d register loads plus reset defaults and %0d live bases,",
             settings_loaded, live_bases);
    $display("%0d residues checked, %0d mismatches, %0d unexpected results.",
             residues_checked, mismatches, strays);
    if (mismatches == 0 && strays == 0 && pending_residues.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
